[hdl/btcr_pkg.sv]
package btcr_pkg;

   // fixed glyph geometry
   localparam int GLYPH_WIDTH      = 8;
   localparam int STORE_ROWS       = 16;
   localparam int TAB_STOPS        = 4;

   // defaults for the top-level parameters
   localparam int GLYPH_HEIGHT_DEF = 16;
   localparam int GLYPH_COUNT_DEF  = 256;

   // character codes and actions
   localparam logic [7:0] CODE_NEWLINE = 8'd10;
   localparam logic [7:0] CODE_TAB     = 8'd9;
   localparam logic       ACT_LOAD     = 1'b0;
   localparam logic       ACT_RENDER   = 1'b1;

   // stream widths
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 32 * (GLYPH_WIDTH + 1);

   // register file
   localparam int CSR_IDX_W = 4;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FORE_COLOUR   = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BACK_COLOUR   = 4'd3;

   localparam logic [15:0] SCREEN_WIDTH_RST  = 16'd1024;
   localparam logic [15:0] SCREEN_HEIGHT_RST = 16'd768;
   localparam logic [31:0] FORE_COLOUR_RST   = 32'hff2997ff;
   localparam logic [31:0] BACK_COLOUR_RST   = 32'h00000000;

   // output queue depth
   localparam int OUT_DEPTH = 3;

   typedef struct packed {
      logic [31:0] back;
      logic [31:0] fore;
      logic [15:0] height;
      logic [15:0] width;
   } cfg_type;

   typedef struct packed {
      logic        last;
      logic [7:0]  bits;
      logic [31:0] idx;
   } row_entry_type;

endpackage

[hdl/bitmap_text_cursor_renderer.sv]
// Bitmap text renderer with a loadable 8-pixel-wide glyph store and a cursor.
// req_ stream: one beat per item. tuser = action (0 load glyph row, 1 render).
//   Load beats write one row byte; newline and tab beats move the cursor.
//   None of these produce output.
// Render beats for other codes produce GLYPH_HEIGHT rsp_ beats, one per glyph
//   row: framebuffer index of the row's leftmost pixel plus eight colours,
//   tlast on the final row. The cursor wraps/homes before drawing and
//   advances by the glyph width after.
// Once accepted, a render beat holds the input through the wrap check, the
//   base index multiply, then one glyph store read per row.
// The glyph store is a single synchronous RAM (one write, one read port,
//   registered read); row reads stream into a 3-entry output queue.
// A stalled receiver backs up the queue; row reads pause on queue credit and
//   resume without loss. req_tready is high whenever no render is in work,
//   even while rows still wait in the queue.
// csr_ beats update the registers (always ready); write only while idle.
// Reset (synchronous): cursor at 0,0, registers to defaults, queue empty.
//   Glyph store contents are undefined until loaded; no clearing pass.
module bitmap_text_cursor_renderer #(
   parameter int GLYPH_HEIGHT = btcr_pkg::GLYPH_HEIGHT_DEF,
   parameter int GLYPH_COUNT  = btcr_pkg::GLYPH_COUNT_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // tdata: char_code[7:0], glyph_row[11:8], glyph_bits[19:12], zero[23:20]
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [btcr_pkg::REQ_DATA_W-1:0]    req_tdata,
   // tuser: action[0]
   input  logic                               req_tuser,
   // tdata: pixel_index[31:0], pixel_0[63:32] ... pixel_7[287:256]
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [btcr_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // tlast: last_row
   output logic                               rsp_tlast,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [btcr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [31:0]                        csr_data
);

   localparam int AW = $clog2(GLYPH_COUNT * btcr_pkg::STORE_ROWS);

   btcr_pkg::cfg_type       cfg_ff, cfg_in;
   btcr_pkg::row_entry_type push_entry;
   logic          wr_en, rd_en, push;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [7:0]    wr_data, rd_data;
   logic [1:0]    out_level;

   // register file; unknown indexes are dropped
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            btcr_pkg::CSR_SCREEN_WIDTH:  cfg_in.width  = csr_data[15:0];
            btcr_pkg::CSR_SCREEN_HEIGHT: cfg_in.height = csr_data[15:0];
            btcr_pkg::CSR_FORE_COLOUR:   cfg_in.fore   = csr_data;
            btcr_pkg::CSR_BACK_COLOUR:   cfg_in.back   = csr_data;
            default:                     cfg_in        = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.width  <= btcr_pkg::SCREEN_WIDTH_RST;
         cfg_ff.height <= btcr_pkg::SCREEN_HEIGHT_RST;
         cfg_ff.fore   <= btcr_pkg::FORE_COLOUR_RST;
         cfg_ff.back   <= btcr_pkg::BACK_COLOUR_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // cursor, wrap, row sequencer
   btcr_render_ctl #(
      .GLYPH_HEIGHT (GLYPH_HEIGHT),
      .GLYPH_COUNT  (GLYPH_COUNT)
   ) u_ctl (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .out_level  (out_level),
      .push       (push),
      .push_entry (push_entry)
   );

   // glyph row store, code*16 + row
   btcr_glyph_mem #(
      .GLYPH_COUNT (GLYPH_COUNT)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // result queue and colour expansion
   btcr_out_fifo u_out (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .push       (push),
      .push_entry (push_entry),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .level      (out_level)
   );

endmodule

[hdl/btcr_glyph_mem.sv]
module btcr_glyph_mem #(
   parameter int GLYPH_COUNT = btcr_pkg::GLYPH_COUNT_DEF,
   localparam int DEPTH = GLYPH_COUNT * btcr_pkg::STORE_ROWS,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/btcr_out_fifo.sv]
module btcr_out_fifo (
   input  logic                              clock,
   input  logic                              reset,
   input  btcr_pkg::cfg_type                 cfg,
   input  logic                              push,
   input  btcr_pkg::row_entry_type           push_entry,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [btcr_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tlast,
   output logic [1:0]                        level
);

   btcr_pkg::row_entry_type entry_ff [btcr_pkg::OUT_DEPTH];
   btcr_pkg::row_entry_type head;
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   function automatic logic [1:0] next_ptr(input logic [1:0] ptr);
      return (ptr == 2'(btcr_pkg::OUT_DEPTH - 1)) ? 2'd0 : ptr + 2'd1;
   endfunction

   assign rsp_tvalid = (count_ff != 2'd0);
   assign pop        = rsp_tvalid & rsp_tready;
   assign level      = count_ff;
   assign head       = entry_ff[rd_ptr_ff];
   assign rsp_tlast  = head.last;

   // expand the row byte into colours, column j from bit 7-j
   always_comb begin
      rsp_tdata[31:0] = head.idx;
      for (int j = 0; j < btcr_pkg::GLYPH_WIDTH; j++) begin
         rsp_tdata[32*(j+1) +: 32] = head.bits[7-j] ? cfg.fore : cfg.back;
      end
   end

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < 2'(btcr_pkg::OUT_DEPTH)) || pop)
      else $error("output queue overflow");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("empty queue with unequal pointers");

   a_valid_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid)
      else $error("result beat dropped while stalled");

endmodule

[hdl/btcr_render_ctl.sv]
module btcr_render_ctl #(
   parameter int GLYPH_HEIGHT = btcr_pkg::GLYPH_HEIGHT_DEF,
   parameter int GLYPH_COUNT  = btcr_pkg::GLYPH_COUNT_DEF,
   localparam int AW = $clog2(GLYPH_COUNT * btcr_pkg::STORE_ROWS)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  btcr_pkg::cfg_type               cfg,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [btcr_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                            req_tuser,
   output logic                            wr_en,
   output logic [AW-1:0]                   wr_addr,
   output logic [7:0]                      wr_data,
   output logic                            rd_en,
   output logic [AW-1:0]                   rd_addr,
   input  logic [7:0]                      rd_data,
   input  logic [1:0]                      out_level,
   output logic                            push,
   output btcr_pkg::row_entry_type         push_entry
);

   localparam int CW = AW - 4;
   localparam int RW = (GLYPH_HEIGHT > 1) ? $clog2(GLYPH_HEIGHT) : 1;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_WRAP = 2'd1;
   localparam logic [1:0] ST_BASE = 2'd2;
   localparam logic [1:0] ST_ROWS = 2'd3;

   localparam logic [7:0] STEP_Y   = 8'(GLYPH_HEIGHT);
   localparam logic [7:0] STEP_X   = 8'(btcr_pkg::GLYPH_WIDTH);
   localparam logic [7:0] STEP_TAB = 8'(btcr_pkg::TAB_STOPS * btcr_pkg::GLYPH_WIDTH);

   logic [1:0]  state_ff, state_in;
   logic [15:0] x_ff, x_in;
   logic [15:0] y_ff, y_in;
   logic [7:0]  code_ff, code_in;
   logic [RW-1:0] row_ff, row_in;
   logic [31:0] idx_ff, idx_in;
   logic        pend_valid_ff, pend_valid_in;
   logic        pend_zero_ff, pend_zero_in;
   logic        pend_last_ff, pend_last_in;
   logic [31:0] pend_idx_ff, pend_idx_in;

   logic        act;
   logic [7:0]  code;
   logic [3:0]  grow;
   logic [7:0]  gbits;
   logic [15:0] wrap_y;
   logic        x_over, wrap_home;
   logic        row_zero, row_last, issue;

   function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [7:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {9'b0, b};
      return s[16] ? 16'hFFFF : s[15:0];
   endfunction

   assign act   = req_tuser;
   assign code  = req_tdata[7:0];
   assign grow  = req_tdata[11:8];
   assign gbits = req_tdata[19:12];

   assign x_over    = (x_ff >= cfg.width);
   assign wrap_y    = x_over ? sat_add(y_ff, STEP_Y) : y_ff;
   assign wrap_home = (wrap_y >= cfg.height);

   // rows past the store or codes past the glyph count render blank
   assign row_zero = ({1'b0, code_ff} >= 9'(GLYPH_COUNT))
                  || (32'(row_ff) >= 32'(btcr_pkg::STORE_ROWS));
   assign row_last = (row_ff == RW'(GLYPH_HEIGHT - 1));
   // credit check: queued rows plus the read in flight
   assign issue = ({1'b0, out_level} + {2'b0, pend_valid_ff}) < 3'(btcr_pkg::OUT_DEPTH);

   assign req_tready = (state_ff == ST_IDLE);
   assign wr_addr    = {code[CW-1:0], grow};
   assign wr_data    = gbits;
   assign rd_addr    = {code_ff[CW-1:0], 4'(row_ff)};

   assign push            = pend_valid_ff;
   assign push_entry.idx  = pend_idx_ff;
   assign push_entry.bits = pend_zero_ff ? 8'h00 : rd_data;
   assign push_entry.last = pend_last_ff;

   always_comb begin
      state_in      = state_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      code_in       = code_ff;
      row_in        = row_ff;
      idx_in        = idx_ff;
      pend_valid_in = 1'b0;
      pend_zero_in  = pend_zero_ff;
      pend_last_in  = pend_last_ff;
      pend_idx_in   = pend_idx_ff;
      wr_en         = 1'b0;
      rd_en         = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (act == btcr_pkg::ACT_LOAD) begin
                  wr_en = ({1'b0, code} < 9'(GLYPH_COUNT));
               end else if (code == btcr_pkg::CODE_NEWLINE) begin
                  x_in = 16'd0;
                  y_in = sat_add(y_ff, STEP_Y);
               end else if (code == btcr_pkg::CODE_TAB) begin
                  x_in = sat_add(x_ff, STEP_TAB);
               end else begin
                  code_in  = code;
                  state_in = ST_WRAP;
               end
            end
         end
         ST_WRAP: begin
            x_in     = (x_over || wrap_home) ? 16'd0 : x_ff;
            y_in     = wrap_home ? 16'd0 : wrap_y;
            state_in = ST_BASE;
         end
         ST_BASE: begin
            idx_in   = ({16'b0, y_ff} * {16'b0, cfg.width}) + {16'b0, x_ff};
            row_in   = '0;
            state_in = ST_ROWS;
         end
         ST_ROWS: begin
            if (issue) begin
               rd_en         = !row_zero;
               pend_valid_in = 1'b1;
               pend_zero_in  = row_zero;
               pend_last_in  = row_last;
               pend_idx_in   = idx_ff;
               idx_in        = idx_ff + {16'b0, cfg.width};
               row_in        = row_ff + RW'(1);
               if (row_last) begin
                  x_in     = sat_add(x_ff, STEP_X);
                  state_in = ST_IDLE;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         x_ff          <= 16'd0;
         y_ff          <= 16'd0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         x_ff          <= x_in;
         y_ff          <= y_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff      <= code_in;
      row_ff       <= row_in;
      idx_ff       <= idx_in;
      pend_zero_ff <= pend_zero_in;
      pend_last_ff <= pend_last_in;
      pend_idx_ff  <= pend_idx_in;
   end

   a_read_in_rows: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> (state_ff == ST_ROWS))
      else $error("glyph read outside row phase");

   a_no_load_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !wr_en)
      else $error("glyph write while rendering");

   a_row_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROWS) |-> (32'(row_ff) < 32'(GLYPH_HEIGHT)))
      else $error("row counter past glyph height");

endmodule

[verif/bitmap_text_cursor_renderer_test.sv]
module bitmap_text_cursor_renderer_test;

   localparam int GLYPH_HEIGHT = btcr_pkg::GLYPH_HEIGHT_DEF;
   localparam int GLYPH_COUNT  = btcr_pkg::GLYPH_COUNT_DEF;
   localparam int STORE_ROWS   = btcr_pkg::STORE_ROWS;
   localparam int STORE_DEPTH  = 256 * STORE_ROWS;

   // quiet time after the last row: render pipeline depth plus margin
   localparam int SETTLE_CYCLES = GLYPH_HEIGHT + 16;
   // receiver hold-off used to back the block up to its input
   localparam int HOLD_CYCLES   = 400;
   // random items per configuration phase; with the preload, the directed
   // walk and the pressure run, about 380 items in all
   localparam int PHASE_ITEMS   = 42;
   localparam int NUM_PHASES    = 7;
   // no register sits at this index; writes to it must be dropped
   localparam logic [btcr_pkg::CSR_IDX_W-1:0] CSR_UNMAPPED = 4'd15;

   // one expected output beat
   typedef struct packed {
      logic [31:0]      index;
      logic [7:0][31:0] colour;
      logic             last;
   } glyph_line_type;

   // directed stimulus row; pin marks a render whose first pixel_index is typed in
   typedef struct packed {
      logic        action;
      logic [7:0]  code;
      logic [3:0]  row;
      logic [7:0]  bits;
      logic        pin;
      logic [31:0] first_index;
   } script_step_type;

   // Directed walk at reset settings (1024 wide). Glyphs 0x00 and 0xff are
   // fully loaded before this runs. Row and bits on render beats are noise.
   localparam int SCRIPT_LEN = 19;
   localparam script_step_type SCRIPT [SCRIPT_LEN] = '{
      '{btcr_pkg::ACT_RENDER, 8'h00, 4'h0, 8'h00, 1'b1, 32'd0},      // home corner
      '{btcr_pkg::ACT_RENDER, 8'hff, 4'h0, 8'h00, 1'b1, 32'd8},
      '{btcr_pkg::ACT_RENDER, btcr_pkg::CODE_NEWLINE, 4'hf, 8'hff, 1'b0, 32'd0}, // y = 16
      '{btcr_pkg::ACT_RENDER, 8'h00, 4'h0, 8'h00, 1'b1, 32'd16384},
      '{btcr_pkg::ACT_RENDER, btcr_pkg::CODE_TAB, 4'h0, 8'h00, 1'b0, 32'd0},     // x += 32
      '{btcr_pkg::ACT_RENDER, 8'hff, 4'h0, 8'h00, 1'b1, 32'd16424},
      '{btcr_pkg::ACT_LOAD,   8'h00, 4'hf, 8'ha5, 1'b0, 32'd0},      // rewrite loaded row
      '{btcr_pkg::ACT_RENDER, 8'h00, 4'h0, 8'h00, 1'b1, 32'd16432},
      '{btcr_pkg::ACT_LOAD,   8'h80, 4'h0, 8'h5a, 1'b0, 32'd0},      // partial glyph
      '{btcr_pkg::ACT_LOAD,   8'hff, 4'h7, 8'h00, 1'b0, 32'd0},
      '{btcr_pkg::ACT_LOAD,   8'h7f, 4'hf, 8'hff, 1'b0, 32'd0},
      '{btcr_pkg::ACT_LOAD,   btcr_pkg::CODE_NEWLINE, 4'h3, 8'h3c, 1'b0, 32'd0}, // load code 10
      '{btcr_pkg::ACT_RENDER, 8'hff, 4'hf, 8'hff, 1'b1, 32'd16440},
      '{btcr_pkg::ACT_RENDER, btcr_pkg::CODE_NEWLINE, 4'h5, 8'h81, 1'b0, 32'd0}, // y = 32
      '{btcr_pkg::ACT_RENDER, 8'h00, 4'h0, 8'h00, 1'b1, 32'd32768},
      '{btcr_pkg::ACT_RENDER, btcr_pkg::CODE_TAB, 4'ha, 8'h55, 1'b0, 32'd0},
      '{btcr_pkg::ACT_RENDER, btcr_pkg::CODE_TAB, 4'h5, 8'haa, 1'b0, 32'd0},
      '{btcr_pkg::ACT_RENDER, 8'hff, 4'h0, 8'h00, 1'b1, 32'd32840},
      '{btcr_pkg::ACT_LOAD,   8'h01, 4'h0, 8'h81, 1'b0, 32'd0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [btcr_pkg::REQ_DATA_W-1:0] req_tdata = '0;   // char_code, glyph_row, glyph_bits, pad
   logic                            req_tuser = btcr_pkg::ACT_LOAD;  // action
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [btcr_pkg::RSP_DATA_W-1:0] rsp_tdata;        // pixel_index, pixel_0 .. pixel_7
   logic                            rsp_tlast;        // last_row
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [btcr_pkg::CSR_IDX_W-1:0]  csr_index = btcr_pkg::CSR_SCREEN_WIDTH;
   logic [31:0]                     csr_data = '0;

   // predictor copy of the block state
   logic [7:0]  glyph_rows  [STORE_DEPTH];
   bit          row_written [STORE_DEPTH];
   bit          glyph_ready [256];
   logic [7:0]  ready_codes [$];    // codes with every store row written
   logic [15:0] scr_width  = btcr_pkg::SCREEN_WIDTH_RST;
   logic [15:0] scr_height = btcr_pkg::SCREEN_HEIGHT_RST;
   logic [31:0] fore       = btcr_pkg::FORE_COLOUR_RST;
   logic [31:0] back       = btcr_pkg::BACK_COLOUR_RST;
   logic [15:0] cur_x      = '0;
   logic [15:0] cur_y      = '0;

   glyph_line_type expected_rows [$];

   int errors        = 0;
   int idle_pct      = 0;     // sender side, stimulus process only
   int stall_pct     = 0;     // receiver side, written by NBA from stimulus
   logic pressure_req = 1'b0;
   bit   pressure_taken = 1'b0;
   int   hold_left   = 0;

   bitmap_text_cursor_renderer #(
      .GLYPH_HEIGHT(GLYPH_HEIGHT),
      .GLYPH_COUNT (GLYPH_COUNT)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // hard stop well past the slowest legal run
   initial begin
      #8000000;
      $display("[bitmap_text_cursor_renderer] ERROR");
      $finish;
   end

   function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      end
   endfunction

   function automatic logic [15:0] sat_add16(logic [15:0] a, int unsigned b);
      logic [16:0] sum;
      sum = {1'b0, a} + 17'(b);
      return sum[16] ? 16'hffff : sum[15:0];
   endfunction

   // Advance the cursor model for one accepted beat and queue the rows it draws.
   task automatic predict_item(input logic action, input logic [7:0] code,
                               input logic [3:0] row, input logic [7:0] bits,
                               output logic [31:0] first_index);
      glyph_line_type line;
      logic [7:0]     pattern;
      bit             complete;
      first_index = '0;
      if (action == btcr_pkg::ACT_LOAD) begin
         if (code < GLYPH_COUNT) begin
            glyph_rows[{code, row}]  = bits;
            row_written[{code, row}] = 1'b1;
            if (!glyph_ready[code]) begin
               complete = 1'b1;
               for (int r = 0; r < STORE_ROWS; r++)
                  complete &= row_written[{code, 4'(r)}];
               if (complete) begin
                  glyph_ready[code] = 1'b1;
                  ready_codes.push_back(code);
               end
            end
         end
      end else if (code == btcr_pkg::CODE_NEWLINE) begin
         cur_x = '0;
         cur_y = sat_add16(cur_y, GLYPH_HEIGHT);
      end else if (code == btcr_pkg::CODE_TAB) begin
         cur_x = sat_add16(cur_x, btcr_pkg::TAB_STOPS * btcr_pkg::GLYPH_WIDTH);
      end else begin
         // wrap to the next text line, then home if off the bottom
         if (cur_x >= scr_width) begin
            cur_x = '0;
            cur_y = sat_add16(cur_y, GLYPH_HEIGHT);
         end
         if (cur_y >= scr_height) begin
            cur_x = '0;
            cur_y = '0;
         end
         for (int unsigned i = 0; i < GLYPH_HEIGHT; i++) begin
            // codes past the glyph count and rows past the store draw blank
            if (code < GLYPH_COUNT && i < STORE_ROWS)
               pattern = glyph_rows[{code, i[3:0]}];
            else
               pattern = '0;
            line.index = 32'(cur_x) + (32'(cur_y) + i) * 32'(scr_width);
            for (int j = 0; j < 8; j++)
               line.colour[j] = pattern[7-j] ? fore : back;   // MSB is leftmost
            line.last = (i == GLYPH_HEIGHT - 1);
            if (i == 0)
               first_index = line.index;
            expected_rows.push_back(line);
         end
         cur_x = sat_add16(cur_x, btcr_pkg::GLYPH_WIDTH);
      end
   endtask

   // Offer one beat, wait for the handshake, then maybe go idle for a while.
   task automatic send_item(input logic action, input logic [7:0] code,
                            input logic [3:0] row, input logic [7:0] bits,
                            output logic [31:0] first_index);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tdata  <= {4'h0, bits, row, code};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      predict_item(action, code, row, bits, first_index);
      gap = 0;
      while (gap < 12 && $urandom_range(99) < idle_pct)
         gap++;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         req_tdata  <= btcr_pkg::REQ_DATA_W'($urandom);   // junk while idle
         req_tuser  <= 1'($urandom);
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_repeat(input logic [7:0] code, input int count);
      logic [31:0] unused;
      repeat (count)
         send_item(btcr_pkg::ACT_RENDER, code, 4'($urandom), 8'($urandom), unused);
   endtask

   // Back-to-back register writes; caller lowers csr_valid when done.
   task automatic csr_write(input logic [btcr_pkg::CSR_IDX_W-1:0] index,
                            input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      case (index)
         btcr_pkg::CSR_SCREEN_WIDTH:  scr_width  = value[15:0];
         btcr_pkg::CSR_SCREEN_HEIGHT: scr_height = value[15:0];
         btcr_pkg::CSR_FORE_COLOUR:   fore       = value;
         btcr_pkg::CSR_BACK_COLOUR:   back       = value;
         default: ;
      endcase
   endtask

   task automatic program_screen(input logic [15:0] w, input logic [15:0] h,
                                 input logic [31:0] f, input logic [31:0] b);
      csr_write(btcr_pkg::CSR_SCREEN_WIDTH, 32'(w));
      csr_write(btcr_pkg::CSR_SCREEN_HEIGHT, 32'(h));
      csr_write(btcr_pkg::CSR_FORE_COLOUR, f);
      csr_write(btcr_pkg::CSR_BACK_COLOUR, b);
      csr_valid <= 1'b0;
   endtask

   // Wait for every queued row, then let any move/load beats retire.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (expected_rows.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [7:0] glyph_byte();
      case ($urandom_range(7))
         0:       return 8'h00;
         1:       return 8'hff;
         default: return 8'($urandom);
      endcase
   endfunction

   // Mostly renders of fully loaded glyphs, with cursor moves, whole-glyph
   // loads and stray single-row loads mixed in.
   task automatic random_item(output int sent);
      int          pick;
      logic [7:0]  code;
      logic [31:0] unused;
      pick = $urandom_range(99);
      sent = 1;
      if (pick < 45 && ready_codes.size() != 0) begin
         code = ready_codes[$urandom_range(ready_codes.size() - 1)];
         send_item(btcr_pkg::ACT_RENDER, code, 4'($urandom), 8'($urandom), unused);
      end else if (pick < 55) begin
         send_item(btcr_pkg::ACT_RENDER, btcr_pkg::CODE_NEWLINE, 4'($urandom),
                   8'($urandom), unused);
      end else if (pick < 62) begin
         send_item(btcr_pkg::ACT_RENDER, btcr_pkg::CODE_TAB, 4'($urandom),
                   8'($urandom), unused);
      end else if (pick < 72) begin
         code = 8'($urandom);
         for (int r = 0; r < STORE_ROWS; r++)
            send_item(btcr_pkg::ACT_LOAD, code, 4'(r), glyph_byte(), unused);
         sent = STORE_ROWS;
      end else begin
         send_item(btcr_pkg::ACT_LOAD, 8'($urandom), 4'($urandom), glyph_byte(), unused);
      end
   endtask

   // Receiver: check each row beat against the oldest expectation, then pick
   // next cycle's ready from the stall rate or a pending long hold-off.
   always @(posedge clock) begin
      glyph_line_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rows.size() == 0) begin
               errors++;
               $display("%0t: row beat with nothing expected, pixel_index %h",
                        $time, rsp_tdata[31:0]);
            end else begin
               want = expected_rows.pop_front();
               check_field("pixel_index", want.index, rsp_tdata[31:0]);
               for (int j = 0; j < 8; j++)
                  check_field($sformatf("pixel_%0d", j), want.colour[j],
                              rsp_tdata[32*(j+1) +: 32]);
               check_field("last_row", 32'(want.last), 32'(rsp_tlast));
            end
         end
         if (pressure_req && !pressure_taken) begin
            pressure_taken = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   initial begin
      int          sent;
      int          count;
      logic [15:0] w;
      logic [15:0] h;
      logic [31:0] f;
      logic [31:0] b;
      logic [31:0] first_index;
      int          s_pct;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Load two complete glyphs so renders never touch unwritten rows.
      // 0x00: walking one, then walking zero; 0xff: alternating full/empty.
      for (int r = 0; r < STORE_ROWS; r++)
         send_item(btcr_pkg::ACT_LOAD, 8'h00, 4'(r),
                   (r < 8) ? (8'h80 >> r) : ~(8'h80 >> (r - 8)), first_index);
      for (int r = 0; r < STORE_ROWS; r++)
         send_item(btcr_pkg::ACT_LOAD, 8'hff, 4'(r), (r % 2 == 0) ? 8'hff : 8'h00,
                   first_index);

      // directed walk at reset settings
      for (int k = 0; k < SCRIPT_LEN; k++) begin
         send_item(SCRIPT[k].action, SCRIPT[k].code, SCRIPT[k].row, SCRIPT[k].bits,
                   first_index);
         if (SCRIPT[k].pin)
            check_field("first pixel_index of directed render", SCRIPT[k].first_index,
                        first_index);
      end

      for (int phase = 1; phase <= NUM_PHASES; phase++) begin
         settle();
         s_pct = 0;
         idle_pct = 0;
         case (phase)
            1: begin   // tiniest screen: glyphs wrap and home, every one drawn at the home corner
               w = 16'd1; h = 16'd1; f = '1; b = '0;
            end
            2: begin   // largest screen, sender idling
               w = 16'hffff; h = 16'hffff; f = '0; b = '1;
            end
            3: begin   // receiver stalling
               w = 16'd20; h = 16'd48; f = $urandom; b = $urandom; s_pct = 52;
            end
            4: begin   // both idling, plus the long hold-off
               w = 16'd640; h = 16'd480; f = $urandom; b = $urandom; s_pct = 28;
            end
            5: begin   // back to reset values; a write to a hole first
               w = btcr_pkg::SCREEN_WIDTH_RST; h = btcr_pkg::SCREEN_HEIGHT_RST;
               f = btcr_pkg::FORE_COLOUR_RST; b = btcr_pkg::BACK_COLOUR_RST;
               csr_write(CSR_UNMAPPED, $urandom);
            end
            6: begin
               w = 16'($urandom_range(1, 65535)); h = 16'($urandom_range(1, 65535));
               f = $urandom; b = $urandom;
            end
            default: begin
               w = 16'($urandom_range(1, 300)); h = 16'($urandom_range(1, 200));
               f = $urandom; b = $urandom; s_pct = 52;
            end
         endcase
         program_screen(w, h, f, b);
         stall_pct <= s_pct;

         if (phase == 4) begin
            // Receiver goes dark for a long stretch while renders keep coming,
            // so the output queue fills and req_tready drops.
            pressure_req <= 1'b1;
            repeat (12)
               send_repeat(ready_codes[$urandom_range(ready_codes.size() - 1)], 1);
         end

         case (phase)
            2, 6:    idle_pct = 52;
            4:       idle_pct = 28;
            default: idle_pct = 0;
         endcase
         count = 0;
         while (count < PHASE_ITEMS) begin
            random_item(sent);
            count += sent;
         end
      end

      settle();
      if (errors == 0)
         $display("[bitmap_text_cursor_renderer] OK");
      else
         $display("[bitmap_text_cursor_renderer] ERROR");
      $finish;
   end

endmodule

[bitmap_text_cursor_renderer.f]
hdl/btcr_pkg.sv
hdl/btcr_glyph_mem.sv
hdl/btcr_out_fifo.sv
hdl/btcr_render_ctl.sv
hdl/bitmap_text_cursor_renderer.sv
verif/bitmap_text_cursor_renderer_test.sv
